// ----- rtl/fpc_pkg.sv -----
package fpc_pkg;

    typedef enum logic [1:0] {
        FUNC_I2H = 2'd0,
        FUNC_H2I = 2'd1,
        FUNC_F2H = 2'd2,
        FUNC_H2F = 2'd3
    } func_t;

    localparam logic [31:0] HalfMaxInt    = 32'd65504;
    localparam logic [4:0]  HalfBias      = 5'd15;
    localparam logic [4:0]  HalfExpAll    = 5'd31;
    localparam logic [7:0]  FloatExpAll   = 8'd255;
    localparam logic [7:0]  RebiasDelta   = 8'd112;   // 127 - 15
    localparam logic [30:0] FloatHalfMax  = 31'h477F_E000;
    localparam logic [15:0] HalfNanCode   = 16'hFFFE;
    localparam logic [31:0] IntMaxCode    = 32'h7FFF_FFFF;
    localparam logic [31:0] IntMinCode    = 32'h8000_0000;

    // Operand classification, worked out once in the first stage.
    typedef struct packed {
        logic int_neg;
        logic int_zero;
        logic int_ovf;
        logic h_small;   // half exponent below the bias
        logic h_max;     // half exponent all ones
        logic h_expz;    // half exponent zero
        logic h_fracz;   // half fraction zero
        logic f_nan;
        logic f_ovf;
        logic f_unf;
    } cls_t;

    typedef struct packed {
        func_t       func;
        logic [31:0] op;
        cls_t        cls;
        logic [15:0] mag;
    } p1_t;

    typedef struct packed {
        func_t       func;
        logic [31:0] op;
        cls_t        cls;
        logic [25:0] src;
        logic [3:0]  sh;
        logic [3:0]  lz;
    } p2_t;

    typedef struct packed {
        func_t       func;
        logic [31:0] op;
        cls_t        cls;
        logic [25:0] shifted;
        logic [3:0]  lz;
    } p3_t;

    function automatic logic [3:0] lzc16(input logic [15:0] v);
        logic [3:0] lz;
        lz = 4'd0;
        for (int i = 0; i < 16; i++) begin
            if (v[i]) begin
                lz = 4'(15 - i);
            end
        end
        return lz;
    endfunction

endpackage

// ----- rtl/fpc_decode.sv -----
module fpc_decode (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         in_valid,
    output logic         in_ready,
    input  logic [1:0]   in_func,
    input  logic [31:0]  in_op,
    output logic         out_valid,
    input  logic         out_ready,
    output fpc_pkg::p1_t out_data
);
    import fpc_pkg::*;

    logic        valid_reg;
    p1_t         data_reg;
    p1_t         data_next;
    logic [31:0] mag32;
    logic [4:0]  hexp;
    logic [7:0]  fexp;

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    always_comb begin
        hexp  = in_op[14:10];
        fexp  = in_op[30:23];
        mag32 = in_op[31] ? (32'd0 - in_op) : in_op;

        data_next.func = func_t'(in_func);
        data_next.op   = in_op;
        data_next.mag  = mag32[15:0];

        data_next.cls.int_neg  = in_op[31];
        data_next.cls.int_zero = (in_op == 32'd0);
        data_next.cls.int_ovf  = (mag32 > HalfMaxInt);
        data_next.cls.h_small  = (hexp < HalfBias);
        data_next.cls.h_max    = (hexp == HalfExpAll);
        data_next.cls.h_expz   = (hexp == 5'd0);
        data_next.cls.h_fracz  = (in_op[9:0] == 10'd0);
        data_next.cls.f_nan    = (fexp == FloatExpAll) && (in_op[22:0] != 23'd0);
        data_next.cls.f_ovf    = (in_op[30:0] > FloatHalfMax);
        data_next.cls.f_unf    = (fexp <= RebiasDelta);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            data_reg <= data_next;
        end
    end

endmodule

// ----- rtl/fpc_norm.sv -----
module fpc_norm (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         in_valid,
    output logic         in_ready,
    input  fpc_pkg::p1_t in_data,
    output logic         out_valid,
    input  logic         out_ready,
    output fpc_pkg::p3_t out_data
);
    import fpc_pkg::*;

    logic        v2_reg;
    logic        v3_reg;
    p2_t         p2_reg;
    p2_t         p2_next;
    p3_t         p3_reg;
    p3_t         p3_next;
    logic        ready3;
    logic [15:0] lz_vec;
    logic [4:0]  h_sh;

    assign ready3    = !v3_reg || out_ready;
    assign in_ready  = !v2_reg || ready3;
    assign out_valid = v3_reg;
    assign out_data  = p3_reg;

    // Leading-one count and shift amount. Integer sources normalize their
    // magnitude; subnormal halves normalize their fraction; half to integer
    // shifts the significand left by the unbiased exponent.
    always_comb begin
        lz_vec = (in_data.func == FUNC_I2H) ? in_data.mag : {in_data.op[9:0], 6'd0};
        h_sh   = in_data.op[14:10] - HalfBias;

        p2_next.func = in_data.func;
        p2_next.op   = in_data.op;
        p2_next.cls  = in_data.cls;
        p2_next.lz   = lzc16(lz_vec);
        if (in_data.func == FUNC_H2I) begin
            p2_next.src = {15'd0, 1'b1, in_data.op[9:0]};
            p2_next.sh  = h_sh[3:0];
        end else begin
            p2_next.src = {10'd0, lz_vec};
            p2_next.sh  = p2_next.lz;
        end
    end

    always_comb begin
        p3_next.func    = p2_reg.func;
        p3_next.op      = p2_reg.op;
        p3_next.cls     = p2_reg.cls;
        p3_next.lz      = p2_reg.lz;
        p3_next.shifted = p2_reg.src << p2_reg.sh;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else begin
            if (in_ready) begin
                v2_reg <= in_valid;
            end
            if (ready3) begin
                v3_reg <= v2_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            p2_reg <= p2_next;
        end
        if (ready3 && v2_reg) begin
            p3_reg <= p3_next;
        end
    end

endmodule

// ----- rtl/fpc_pack.sv -----
module fpc_pack (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         in_valid,
    output logic         in_ready,
    input  fpc_pkg::p3_t in_data,
    output logic         out_valid,
    input  logic         out_ready,
    output logic [31:0]  out_bits
);
    import fpc_pkg::*;

    logic        valid_reg;
    logic [31:0] bits_reg;
    logic [31:0] bits_next;
    logic [15:0] norm;
    logic [31:0] ival;
    logic        s16;
    logic [7:0]  fexp_sub;
    logic [7:0]  hexp_add;

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_bits  = bits_reg;

    always_comb begin
        norm     = in_data.shifted[15:0];
        ival     = {16'd0, in_data.shifted[25:10]};
        s16      = in_data.op[15];
        fexp_sub = in_data.op[30:23] - RebiasDelta;
        hexp_add = {3'd0, in_data.op[14:10]} + RebiasDelta;
        bits_next = 32'd0;
        unique case (in_data.func)
            FUNC_I2H: begin
                if (in_data.cls.int_zero) begin
                    bits_next = 32'd0;
                end else if (in_data.cls.int_ovf) begin
                    bits_next = {16'd0, in_data.cls.int_neg, HalfExpAll, 10'd0};
                end else begin
                    bits_next = {16'd0, in_data.cls.int_neg,
                                 5'(5'd30 - {1'b0, in_data.lz}), norm[14:5]};
                end
            end
            FUNC_H2I: begin
                if (in_data.cls.h_max) begin
                    bits_next = (in_data.cls.h_fracz && !s16) ? IntMaxCode : IntMinCode;
                end else if (in_data.cls.h_small) begin
                    bits_next = 32'd0;
                end else begin
                    bits_next = s16 ? (32'd0 - ival) : ival;
                end
            end
            FUNC_F2H: begin
                if (in_data.cls.f_nan) begin
                    bits_next = {16'd0, HalfNanCode};
                end else if (in_data.cls.f_ovf) begin
                    bits_next = {16'd0, in_data.op[31], HalfExpAll, 10'd0};
                end else if (in_data.cls.f_unf) begin
                    bits_next = 32'd0;
                end else begin
                    bits_next = {16'd0, in_data.op[31], fexp_sub[4:0], in_data.op[22:13]};
                end
            end
            FUNC_H2F: begin
                if (in_data.cls.h_max) begin
                    bits_next = {s16, FloatExpAll, in_data.op[9:0], 13'd0};
                end else if (in_data.cls.h_expz) begin
                    if (in_data.cls.h_fracz) begin
                        bits_next = {s16, 31'd0};
                    end else begin
                        // Subnormal half: leading one of the fraction sets the exponent.
                        bits_next = {s16, 8'(RebiasDelta - {4'd0, in_data.lz}),
                                     norm[14:6], 14'd0};
                    end
                end else begin
                    bits_next = {s16, hexp_add, in_data.op[9:0], 13'd0};
                end
            end
            default: begin
                bits_next = 32'd0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            bits_reg <= bits_next;
        end
    end

endmodule

// ----- rtl/half_precision_format_converter.sv -----
// Binary16 format converter, truncating toward zero. Each transfer on the
// input carries one operand in s_tdata and an operation code in s_tuser
// (0 int32 to half, 1 half to int32, 2 float32 to half, 3 half to float32).
// Each operand produces exactly one result transfer. Half results sit in the
// low 16 bits and the upper bits are zero. The block is a four-stage
// pipeline: classify and negate, leading-one count, barrel shift, then pack
// into the output register. An accepted operand moves through these stage
// registers in order before its result is shown on m_tdata. One operand is
// accepted every cycle while m_tready is high. A stall on the output backs
// up through the stage registers without losing any transfer.
module half_precision_format_converter (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [31:0] operand_bits
    input  logic [1:0]  s_tuser,   // [1:0] func
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata    // [31:0] result_bits
);
    import fpc_pkg::*;

    logic v1;
    logic r1;
    p1_t  d1;
    logic v3;
    logic r3;
    p3_t  d3;

    fpc_decode u_decode (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_func   (s_tuser),
        .in_op     (s_tdata),
        .out_valid (v1),
        .out_ready (r1),
        .out_data  (d1)
    );

    fpc_norm u_norm (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (v1),
        .in_ready  (r1),
        .in_data   (d1),
        .out_valid (v3),
        .out_ready (r3),
        .out_data  (d3)
    );

    fpc_pack u_pack (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (v3),
        .in_ready  (r3),
        .in_data   (d3),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_bits  (m_tdata)
    );

endmodule

// ----- rtl/fpc_checker.sv -----
module fpc_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic [31:0] s_tdata,
    input logic [1:0]  s_tuser,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [31:0] m_tdata
);
    import fpc_pkg::*;

    logic acc;
    assign acc = s_tvalid && s_tready;

    // Reset empties the pipeline.
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

    // A held result keeps its data.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result changed");

    // With the output draining, no stage may hold back the input.
    a_no_bubble_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tready |-> s_tready)
        else $error("input stalled while output is ready");

    // An accepted operand reaches the output as a valid result when the output never stalls.
    a_latency: assert property (@(posedge aclk) disable iff (!aresetn)
        (acc && m_tready) ##1 m_tready ##1 m_tready ##1 m_tready |=> m_tvalid)
        else $error("result missing four cycles after operand");

    // Integer zero converts to half zero.
    a_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (acc && s_tuser == FUNC_I2H && s_tdata == 32'd0 && m_tready)
        ##1 m_tready ##1 m_tready ##1 m_tready |=> m_tdata == 32'd0)
        else $error("integer zero did not give half zero");

endmodule

bind half_precision_format_converter fpc_checker u_fpc_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
